// ===== rtl/mono_page_framebuffer_dirty_flush_assert.svh =====
// Assertion macros for the page frame store block.
// Included by the top level; depends on nothing else.
`ifndef MONO_PAGE_FRAMEBUFFER_DIRTY_FLUSH_ASSERT_SVH
`define MONO_PAGE_FRAMEBUFFER_DIRTY_FLUSH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPFB_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mpfb_pkg.sv =====
// Shared types, operation codes and panel constants for the page frame store.
// Used by every module of the block; depends on nothing.
package mpfb_pkg;

  localparam int MEM_AW           = 10;
  localparam int BYTES_PER_RESULT = 8;

  localparam logic [7:0] CMD_PAGE_BASE     = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW_MASK  = 8'h0F;
  localparam logic [7:0] CMD_COL_HIGH_BASE = 8'h10;
  localparam logic [7:0] CMD_COL_LOW_ZERO  = 8'h00;
  localparam logic [7:0] FILL_ONES         = 8'hFF;
  localparam logic [7:0] FILL_ZEROS        = 8'h00;
  localparam logic [3:0] CMD_BYTES         = 4'd3;

  typedef enum logic [2:0] {
    OP_SET_PIXEL  = 3'd0,
    OP_GET_PIXEL  = 3'd1,
    OP_HLINE      = 3'd2,
    OP_VLINE      = 3'd3,
    OP_CLEAR_PAGE = 3'd4,
    OP_FLUSH_PAGE = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DECODE,
    ST_DRAW,
    ST_GET,
    ST_ACK,
    ST_FILL,
    ST_CMD,
    ST_RUN,
    ST_DATA
  } state_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] x_start;
    logic [7:0] x_end;
    logic [7:0] y_start;
    logic [7:0] y_end;
    logic       color;
    logic [2:0] page_index;
  } item_t;

  typedef struct packed {
    logic        is_data;
    logic [3:0]  byte_count;
    logic [63:0] payload;
    logic        pixel_value;
    logic        last;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [MEM_AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic       mark;
    logic       clear;
    logic [2:0] page;
    logic [7:0] lo;
    logic [6:0] hi;
  } mark_req_t;

  typedef struct packed {
    logic       dirty;
    logic [7:0] first;
    logic [6:0] last;
  } mark_view_t;

  function automatic logic [MEM_AW-1:0] cell_addr(input logic [2:0] page,
                                                  input logic [7:0] col);
    return {page, col[6:0]};
  endfunction

endpackage

// ===== rtl/mpfb_store.sv =====
// Frame store: column bytes of all pages, one write and one read port,
// read data registered. Depends on mpfb_pkg.
module mpfb_store import mpfb_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic       clk,
  input  mem_req_t   req,
  output logic [7:0] rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr[AW-1:0]];
    end
  end

endmodule

// ===== rtl/mpfb_marks.sv =====
// Per-page dirty marks: flag plus lowest and highest changed column.
// Depends on mpfb_pkg.
module mpfb_marks import mpfb_pkg::*; #(
  parameter int PANEL_WIDTH = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  mark_req_t  req,
  input  logic [2:0] rd_page,
  output mark_view_t view
);

  logic       dirty [8];
  logic [7:0] first [8];
  logic [6:0] last  [8];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < 8; p++) begin
        dirty[p] <= 1'b0;
        first[p] <= 8'(PANEL_WIDTH);
        last[p]  <= 7'd0;
      end
    end else if (req.clear) begin
      dirty[req.page] <= 1'b0;
      first[req.page] <= 8'(PANEL_WIDTH);
      last[req.page]  <= 7'd0;
    end else if (req.mark) begin
      dirty[req.page] <= 1'b1;
      if (first[req.page] > req.lo) begin
        first[req.page] <= req.lo;
      end
      if (last[req.page] < req.hi) begin
        last[req.page] <= req.hi;
      end
    end
  end

  assign view = '{dirty: dirty[rd_page], first: first[rd_page], last: last[rd_page]};

endmodule

// ===== rtl/mpfb_ctrl.sv =====
// Sequencer: clears the store after reset, decodes items, runs the
// read-modify-write draws, page fills and byte runs. Depends on mpfb_pkg.
module mpfb_ctrl import mpfb_pkg::*; #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  item_t      in_item,
  output mem_req_t   mem_req,
  input  logic [7:0] mem_rdata,
  output mark_req_t  mreq,
  output logic [2:0] mpage,
  input  mark_view_t mview,
  output logic       res_valid,
  output result_t    res,
  input  logic       res_free,
  output logic       sweeping
);

  localparam int NUM_PAGES = (PANEL_HEIGHT + 7) / 8;
  localparam logic [7:0] W8     = 8'(PANEL_WIDTH);
  localparam logic [7:0] W_LAST = 8'(PANEL_WIDTH - 1);
  localparam logic [7:0] H8     = 8'(PANEL_HEIGHT);
  localparam logic [7:0] H_LAST = 8'(PANEL_HEIGHT - 1);
  localparam logic [3:0] NP4    = 4'(NUM_PAGES);
  localparam logic [MEM_AW-1:0] SWEEP_LAST = MEM_AW'(NUM_PAGES * 128 - 1);
  localparam logic [3:0] GRP_LAST = 4'(BYTES_PER_RESULT - 1);

  state_t            state, state_next;
  item_t             item, item_next;
  logic [7:0]        cur_col, cur_col_next, end_col, end_col_next;
  logic [2:0]        cur_page, cur_page_next, end_page, end_page_next;
  logic              pix, pix_next;
  logic [MEM_AW-1:0] sweep_addr, sweep_addr_next;
  logic              wpend_valid, wpend_valid_next;
  logic [MEM_AW-1:0] wpend_addr, wpend_addr_next;
  logic [7:0]        wpend_mask, wpend_mask_next;
  logic              pend_valid, pend_valid_next;
  logic [2:0]        pend_idx, pend_idx_next;
  logic [3:0]        grp_n, grp_n_next;
  logic              run_done, run_done_next;
  logic [63:0]       acc, acc_next;

  logic       on_panel, page_ok;
  logic [7:0] xe_c, ye_c, first_c, last_c, last_k;
  logic [2:0] lo_b, hi_b;
  logic [7:0] vmask, fill;

  assign on_panel = (item.x_start < W8) && (item.y_start < H8);
  assign page_ok  = {1'b0, item.page_index} < NP4;
  assign xe_c     = (item.x_end >= W8) ? W_LAST : item.x_end;
  assign ye_c     = (item.y_end >= H8) ? H_LAST : item.y_end;
  assign first_c  = (mview.first >= W8) ? W_LAST : mview.first;
  assign last_k   = ({1'b0, mview.last} >= W8) ? W_LAST : {1'b0, mview.last};
  assign last_c   = (last_k < first_c) ? first_c : last_k;
  assign lo_b     = (cur_page == item.y_start[5:3]) ? item.y_start[2:0] : 3'd0;
  assign hi_b     = (cur_page == ye_c[5:3]) ? ye_c[2:0] : 3'd7;
  assign vmask    = (8'hFF << lo_b) & (8'hFF >> (3'd7 - hi_b));
  assign fill     = item.color ? FILL_ONES : FILL_ZEROS;

  assign mpage    = item.page_index;
  assign in_ready = (state == ST_IDLE);
  assign sweeping = (state == ST_SWEEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      sweep_addr  <= '0;
      wpend_valid <= 1'b0;
      pend_valid  <= 1'b0;
    end else begin
      state       <= state_next;
      sweep_addr  <= sweep_addr_next;
      wpend_valid <= wpend_valid_next;
      pend_valid  <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    item       <= item_next;
    cur_col    <= cur_col_next;
    end_col    <= end_col_next;
    cur_page   <= cur_page_next;
    end_page   <= end_page_next;
    pix        <= pix_next;
    wpend_addr <= wpend_addr_next;
    wpend_mask <= wpend_mask_next;
    pend_idx   <= pend_idx_next;
    grp_n      <= grp_n_next;
    run_done   <= run_done_next;
    acc        <= acc_next;
  end

  always_comb begin
    state_next       = state;
    item_next        = item;
    cur_col_next     = cur_col;
    end_col_next     = end_col;
    cur_page_next    = cur_page;
    end_page_next    = end_page;
    pix_next         = pix;
    sweep_addr_next  = sweep_addr;
    wpend_valid_next = 1'b0;
    wpend_addr_next  = wpend_addr;
    wpend_mask_next  = wpend_mask;
    pend_valid_next  = 1'b0;
    pend_idx_next    = pend_idx;
    grp_n_next       = grp_n;
    run_done_next    = run_done;
    acc_next         = acc;
    mem_req          = '0;
    mreq             = '0;
    res_valid        = 1'b0;
    res              = '0;

    // Write-back half of a draw: data read last cycle, modified by the mask.
    if (wpend_valid) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = wpend_addr;
      mem_req.wdata = item.color ? (mem_rdata | wpend_mask) : (mem_rdata & ~wpend_mask);
    end
    // Packing half of a byte run.
    if (pend_valid) begin
      acc_next[{pend_idx, 3'b000} +: 8] = mem_rdata;
    end

    case (state)
      ST_SWEEP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = sweep_addr;
        mem_req.wdata = FILL_ZEROS;
        sweep_addr_next = sweep_addr + 1'b1;
        if (sweep_addr == SWEEP_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          item_next  = in_item;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        pix_next      = 1'b0;
        cur_col_next  = item.x_start;
        end_col_next  = item.x_start;
        cur_page_next = item.y_start[5:3];
        end_page_next = item.y_start[5:3];
        state_next    = ST_ACK;
        case (item.operation)
          OP_SET_PIXEL: begin
            if (on_panel) begin
              mreq = '{mark: 1'b1, clear: 1'b0, page: item.y_start[5:3],
                       lo: item.x_start, hi: item.x_start[6:0]};
              state_next = ST_DRAW;
            end
          end
          OP_HLINE: begin
            if (on_panel && (xe_c >= item.x_start)) begin
              end_col_next = xe_c;
              mreq = '{mark: 1'b1, clear: 1'b0, page: item.y_start[5:3],
                       lo: item.x_start, hi: xe_c[6:0]};
              state_next = ST_DRAW;
            end
          end
          OP_VLINE: begin
            if (on_panel && (ye_c >= item.y_start)) begin
              end_page_next = ye_c[5:3];
              state_next    = ST_DRAW;
            end
          end
          OP_GET_PIXEL: begin
            if (on_panel) begin
              mem_req.re    = 1'b1;
              mem_req.raddr = cell_addr(item.y_start[5:3], item.x_start);
              state_next    = ST_GET;
            end
          end
          OP_CLEAR_PAGE: begin
            if (page_ok) begin
              mreq.clear   = 1'b1;
              mreq.page    = item.page_index;
              cur_col_next = 8'd0;
              state_next   = ST_FILL;
            end
          end
          OP_FLUSH_PAGE: begin
            if (page_ok && mview.dirty) begin
              mreq.clear   = 1'b1;
              mreq.page    = item.page_index;
              cur_col_next = first_c;
              end_col_next = last_c;
              state_next   = ST_CMD;
            end
          end
          default: begin
            state_next = ST_ACK;
          end
        endcase
      end
      ST_DRAW: begin
        mem_req.re       = 1'b1;
        mem_req.raddr    = cell_addr(cur_page, cur_col);
        wpend_valid_next = 1'b1;
        wpend_addr_next  = cell_addr(cur_page, cur_col);
        if (item.operation == OP_VLINE) begin
          wpend_mask_next = vmask;
          mreq = '{mark: 1'b1, clear: 1'b0, page: cur_page,
                   lo: item.x_start, hi: item.x_start[6:0]};
          cur_page_next = cur_page + 1'b1;
          if (cur_page == end_page) begin
            state_next = ST_ACK;
          end
        end else begin
          wpend_mask_next = 8'h01 << item.y_start[2:0];
          cur_col_next    = cur_col + 1'b1;
          if (cur_col == end_col) begin
            state_next = ST_ACK;
          end
        end
      end
      ST_GET: begin
        pix_next   = mem_rdata[item.y_start[2:0]];
        state_next = ST_ACK;
      end
      ST_ACK: begin
        if (res_free) begin
          res_valid       = 1'b1;
          res.pixel_value = pix;
          res.last        = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cell_addr(item.page_index, cur_col);
        mem_req.wdata = fill;
        cur_col_next  = cur_col + 1'b1;
        if (cur_col == W_LAST) begin
          cur_col_next = 8'd0;
          end_col_next = W_LAST;
          state_next   = ST_CMD;
        end
      end
      ST_CMD: begin
        grp_n_next    = 4'd0;
        run_done_next = 1'b0;
        acc_next      = '0;
        if (res_free) begin
          res_valid      = 1'b1;
          res.byte_count = CMD_BYTES;
          if (item.operation == OP_CLEAR_PAGE) begin
            res.payload = {40'd0, CMD_PAGE_BASE + {5'd0, item.page_index},
                           CMD_COL_HIGH_BASE, CMD_COL_LOW_ZERO};
          end else begin
            res.payload = {40'd0, {4'd0, cur_col[7:4]} | CMD_COL_HIGH_BASE,
                           cur_col & CMD_COL_LOW_MASK,
                           CMD_PAGE_BASE + {5'd0, item.page_index}};
          end
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        mem_req.re      = 1'b1;
        mem_req.raddr   = cell_addr(item.page_index, cur_col);
        pend_valid_next = 1'b1;
        pend_idx_next   = grp_n[2:0];
        grp_n_next      = grp_n + 1'b1;
        cur_col_next    = cur_col + 1'b1;
        if (cur_col == end_col) begin
          run_done_next = 1'b1;
        end
        if ((cur_col == end_col) || (grp_n == GRP_LAST)) begin
          state_next = ST_DATA;
        end
      end
      ST_DATA: begin
        if (!pend_valid && res_free) begin
          res_valid      = 1'b1;
          res.is_data    = 1'b1;
          res.byte_count = grp_n;
          res.payload    = acc;
          res.last       = run_done;
          acc_next       = '0;
          grp_n_next     = 4'd0;
          state_next     = run_done ? ST_IDLE : ST_RUN;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/mpfb_obuf.sv =====
// Output register: holds one result until the receiver takes it.
// Depends on mpfb_pkg.
module mpfb_obuf import mpfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        res_valid,
  input  result_t     res,
  output logic        res_free,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,
  output logic        m_tuser,
  output logic        m_tlast
);

  result_t held;

  assign res_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      held <= res;
    end
  end

  assign m_tdata = {3'b000, held.pixel_value, held.payload, held.byte_count};
  assign m_tuser = held.is_data;
  assign m_tlast = held.last;

endmodule

// ===== rtl/mono_page_framebuffer_dirty_flush.sv =====
// Top level of the page-organised monochrome frame store with dirty flush.
// Depends on mpfb_pkg, mpfb_store, mpfb_marks, mpfb_ctrl, mpfb_obuf and the assert header.
//
// Drawing commands arrive on the slave stream, one transaction per item, with
// the operation code in s_tuser. Each item produces one or more result
// transactions on the master stream; m_tlast marks the final one of an item
// and m_tuser says whether the bytes are panel commands or display data.
// Pixels sit in one frame store of (pages x 128) column bytes with one write
// port and one read port and a registered read; that pair of ports sets the timing.
// Set pixel and the lines read each column byte they touch and write it back;
// get pixel reads one byte. A page clear writes all columns at one per cycle,
// then emits one command transaction and the page as data; a flush emits the
// command and then the dirty run; each data transaction holds up to eight bytes.
// After reset the sequencer writes zeros through the store, one entry per
// cycle ((PANEL_HEIGHT + 7) / 8 * 128 entries, 1024 at the defaults), with
// s_tready low until that pass ends; the dirty marks reset at once. A finished
// result waits in an output register while the next item is taken; if the
// receiver stalls with a second result ready, the sequencer waits, losing nothing.
`include "mono_page_framebuffer_dirty_flush_assert.svh"

module mono_page_framebuffer_dirty_flush import mpfb_pkg::*; #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // x_start [7:0], x_end [15:8], y_start [23:16], y_end [31:24],
  // color [32], page_index [35:33], zero fill [39:36]
  input  logic [39:0] s_tdata,
  // operation [2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // byte_count [3:0], payload [67:4], pixel_value [68], zero fill [71:69]
  output logic [71:0] m_tdata,
  // is_data [0]
  output logic        m_tuser,
  output logic        m_tlast
);

  localparam int NUM_PAGES = (PANEL_HEIGHT + 7) / 8;
  localparam int MEM_DEPTH = NUM_PAGES * 128;

  item_t      in_item;
  mem_req_t   mem_req;
  logic [7:0] mem_rdata;
  mark_req_t  mreq;
  logic [2:0] mpage;
  mark_view_t mview;
  logic       res_valid;
  result_t    res;
  logic       res_free;
  logic       sweeping;

  // Unpack the slave transaction into the item fields.
  assign in_item = '{operation:  s_tuser,
                     x_start:    s_tdata[7:0],
                     x_end:      s_tdata[15:8],
                     y_start:    s_tdata[23:16],
                     y_end:      s_tdata[31:24],
                     color:      s_tdata[32],
                     page_index: s_tdata[35:33]};

  mpfb_store #(
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  mpfb_marks #(
    .PANEL_WIDTH (PANEL_WIDTH)
  ) u_marks (
    .clk     (clk),
    .rst     (rst),
    .req     (mreq),
    .rd_page (mpage),
    .view    (mview)
  );

  mpfb_ctrl #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .mreq      (mreq),
    .mpage     (mpage),
    .mview     (mview),
    .res_valid (res_valid),
    .res       (res),
    .res_free  (res_free),
    .sweeping  (sweeping)
  );

  mpfb_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_free  (res_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // A draw writes back one entry while reading the next; they must differ.
  `MPFB_ASSERT_HOLDS(a_no_rw_collision, clk, rst, mem_req.we && mem_req.re,
                     mem_req.waddr != mem_req.raddr,
                     "frame store read and write hit the same entry")
  // No item may enter while the store is still being cleared.
  `MPFB_ASSERT_HOLDS(a_sweep_blocks_input, clk, rst, sweeping, !s_tready,
                     "item accepted during the clearing pass")
  // An accepted item is decoded before another one is taken.
  `MPFB_ASSERT_NEXT(a_one_item_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready,
                    "second item taken before decode")
  // A result never carries more bytes than one transaction holds.
  `MPFB_ASSERT_HOLDS(a_count_bound, clk, rst, m_tvalid,
                     m_tdata[3:0] <= 4'(BYTES_PER_RESULT),
                     "byte count exceeds the result size")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the page-organised monochrome frame store with dirty flush.
// Depends on mpfb_pkg and the top level mono_page_framebuffer_dirty_flush only.
// It predicts every result transaction and compares it field by field.
`timescale 1ns / 100ps

module tb_top;
  import mpfb_pkg::*;

  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int NUM_PAGES    = (PANEL_HEIGHT + 7) / 8;
  // The two operation codes that the block treats as plain acknowledgements.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  // The clearing pass after reset is the longest quiet stretch of a correct run;
  // a page clear is also quiet while it fills its page, before its first result.
  localparam int QUIET_LIMIT  = 8000;
  localparam int TAIL_CYCLES  = 64;
  localparam int RANDOM_ITEMS = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  mono_page_framebuffer_dirty_flush #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Drawing items still to be offered, and the panel transactions that the
  // frame store is expected to send, oldest first.
  item_t   draw_q[$];
  result_t panel_q[$];

  // Shadow copy of the frame store and of the per-page dirty marks.
  logic [7:0] shadow_fb [PANEL_WIDTH * 8];
  logic       shadow_dirty [8];
  logic [7:0] shadow_first [8];
  logic [6:0] shadow_last  [8];

  int  mismatches = 0;
  int  quiet_cycles = 0;
  int  items_taken = 0;
  int  results_taken = 0;
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;

  // ---------------------------------------------------------------------------
  // Shadow frame store. Every accepted item is applied here at the moment of
  // its acceptance, and the transactions it must cause are queued.
  // ---------------------------------------------------------------------------
  function automatic void queue_result(logic is_data, logic [3:0] count,
                                       logic [63:0] bytes, logic pix, logic fin);
    result_t r;
    r.is_data     = is_data;
    r.byte_count  = count;
    r.payload     = bytes;
    r.pixel_value = pix;
    r.last        = fin;
    panel_q.push_back(r);
  endfunction

  function automatic void reset_mark(int pg);
    shadow_dirty[pg] = 1'b0;
    shadow_first[pg] = 8'(PANEL_WIDTH);
    shadow_last[pg]  = '0;
  endfunction

  function automatic void widen_mark(int pg, int lo, int hi);
    shadow_dirty[pg] = 1'b1;
    if (shadow_first[pg] > lo) shadow_first[pg] = 8'(lo);
    if (shadow_last[pg] < hi) shadow_last[pg] = 7'(hi);
  endfunction

  function automatic void paint(int idx, logic [7:0] mask, logic lit);
    if (lit) shadow_fb[idx] = shadow_fb[idx] | mask;
    else shadow_fb[idx] = shadow_fb[idx] & ~mask;
  endfunction

  // Columns first..lastc of a page go out as data transactions of up to
  // BYTES_PER_RESULT bytes; the final one closes the item.
  function automatic void queue_column_run(int pg, int first, int lastc);
    int col;
    int n;
    logic [63:0] bytes;
    col = first;
    while (col <= lastc) begin
      bytes = '0;
      n = 0;
      while (n < BYTES_PER_RESULT && col <= lastc) begin
        bytes = bytes | (64'(shadow_fb[pg * PANEL_WIDTH + col]) << (8 * n));
        n++;
        col++;
      end
      queue_result(1'b1, 4'(n), bytes, 1'b0, col > lastc);
    end
  endfunction

  function automatic void apply_draw_item(item_t it);
    int xs, xe, ys, ye, pg, i, first, lastc;
    logic pix;
    logic [7:0] fill;
    logic [63:0] cmd;
    xs = it.x_start;
    xe = it.x_end;
    ys = it.y_start;
    ye = it.y_end;
    pg = it.page_index;
    case (it.operation)
      OP_SET_PIXEL: begin
        if (xs < PANEL_WIDTH && ys < PANEL_HEIGHT) begin
          paint((ys / 8) * PANEL_WIDTH + xs, 8'(1 << (ys % 8)), it.color);
          widen_mark(ys / 8, xs, xs);
        end
        queue_result(1'b0, 4'd0, '0, 1'b0, 1'b1);
      end
      OP_GET_PIXEL: begin
        pix = 1'b0;
        if (xs < PANEL_WIDTH && ys < PANEL_HEIGHT)
          pix = shadow_fb[(ys / 8) * PANEL_WIDTH + xs][ys % 8];
        queue_result(1'b0, 4'd0, '0, pix, 1'b1);
      end
      OP_HLINE: begin
        if (xs < PANEL_WIDTH && ys < PANEL_HEIGHT) begin
          if (xe >= PANEL_WIDTH) xe = PANEL_WIDTH - 1;
          if (xe >= xs) begin
            for (i = xs; i <= xe; i++)
              paint((ys / 8) * PANEL_WIDTH + i, 8'(1 << (ys % 8)), it.color);
            widen_mark(ys / 8, xs, xe);
          end
        end
        queue_result(1'b0, 4'd0, '0, 1'b0, 1'b1);
      end
      OP_VLINE: begin
        if (xs < PANEL_WIDTH && ys < PANEL_HEIGHT) begin
          if (ye >= PANEL_HEIGHT) ye = PANEL_HEIGHT - 1;
          for (i = ys; i <= ye; i++) begin
            paint((i / 8) * PANEL_WIDTH + xs, 8'(1 << (i % 8)), it.color);
            widen_mark(i / 8, xs, xs);
          end
        end
        queue_result(1'b0, 4'd0, '0, 1'b0, 1'b1);
      end
      OP_CLEAR_PAGE: begin
        if (pg >= NUM_PAGES) begin
          queue_result(1'b0, 4'd0, '0, 1'b0, 1'b1);
        end else begin
          fill = it.color ? FILL_ONES : FILL_ZEROS;
          for (i = 0; i < PANEL_WIDTH; i++) shadow_fb[pg * PANEL_WIDTH + i] = fill;
          reset_mark(pg);
          cmd = 64'(CMD_COL_LOW_ZERO) | (64'(CMD_COL_HIGH_BASE) << 8)
              | (64'(8'(CMD_PAGE_BASE + pg)) << 16);
          queue_result(1'b0, CMD_BYTES, cmd, 1'b0, 1'b0);
          queue_column_run(pg, 0, PANEL_WIDTH - 1);
        end
      end
      OP_FLUSH_PAGE: begin
        if (pg >= NUM_PAGES || !shadow_dirty[pg]) begin
          queue_result(1'b0, 4'd0, '0, 1'b0, 1'b1);
        end else begin
          first = shadow_first[pg];
          lastc = shadow_last[pg];
          if (first >= PANEL_WIDTH) first = PANEL_WIDTH - 1;
          if (lastc >= PANEL_WIDTH) lastc = PANEL_WIDTH - 1;
          if (lastc < first) lastc = first;
          cmd = 64'(8'(CMD_PAGE_BASE + pg))
              | (64'(8'(first) & CMD_COL_LOW_MASK) << 8)
              | (64'(8'(first >> 4) | CMD_COL_HIGH_BASE) << 16);
          queue_result(1'b0, CMD_BYTES, cmd, 1'b0, 1'b0);
          queue_column_run(pg, first, lastc);
          reset_mark(pg);
        end
      end
      default: queue_result(1'b0, 4'd0, '0, 1'b0, 1'b1);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------------
  function automatic void add_item(logic [2:0] op, int xs, int xe, int ys, int ye,
                                   logic lit, int pg);
    item_t it;
    it.operation  = op;
    it.x_start    = 8'(xs);
    it.x_end      = 8'(xe);
    it.y_start    = 8'(ys);
    it.y_end      = 8'(ye);
    it.color      = lit;
    it.page_index = 3'(pg);
    draw_q.push_back(it);
  endfunction

  // A well-formed drawing item: start coordinates on the panel, mostly short lines
  // so that flushes send runs of varied length, with the odd long one.
  function automatic void add_sensible_item();
    int sel, xs, ys;
    sel = $urandom_range(0, 19);
    xs = $urandom_range(0, PANEL_WIDTH - 1);
    ys = $urandom_range(0, PANEL_HEIGHT - 1);
    if (sel < 5)
      add_item(OP_SET_PIXEL, xs, 0, ys, 0, 1'($urandom_range(0, 1)), 0);
    else if (sel < 8)
      add_item(OP_GET_PIXEL, xs, 0, ys, 0, 0, 0);
    else if (sel < 11)
      add_item(OP_HLINE, xs, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
               : xs + $urandom_range(0, 20), ys, 0, 1'($urandom_range(0, 1)), 0);
    else if (sel < 14)
      add_item(OP_VLINE, xs, 0, ys, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
               : ys + $urandom_range(0, 20), 1'($urandom_range(0, 1)), 0);
    else if (sel < 19)
      add_item(OP_FLUSH_PAGE, 0, 0, 0, 0, 0, $urandom_range(0, NUM_PAGES - 1));
    else
      add_item(OP_CLEAR_PAGE, 0, 0, 0, 0, 1'($urandom_range(0, 1)),
               $urandom_range(0, NUM_PAGES - 1));
  endfunction

  // Noise: every field drawn over its full width, spare operations included.
  function automatic void add_noise_item();
    logic [63:0] bits;
    item_t it;
    bits = {$urandom(), $urandom()};
    it = bits[$bits(item_t)-1:0];
    draw_q.push_back(it);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. One item is presented at a time; after each transaction the sender
  // may pause before the next item, except in every fourth stretch of 30 items,
  // where it offers items back to back.
  // ---------------------------------------------------------------------------
  item_t cur_item;
  logic  in_busy = 1'b0;
  int    in_gap = 0;

  always @(negedge clk) begin
    if (!rst) begin
      if (in_fire) begin
        in_busy = 1'b0;
        in_gap = ((items_taken / 30) % 4 == 3) ? 0 : $urandom_range(0, 7);
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (draw_q.size() > 0) begin
          cur_item = draw_q.pop_front();
          in_busy = 1'b1;
        end
      end
      s_tvalid <= in_busy;
      if (in_busy) begin
        s_tuser <= cur_item.operation;
        s_tdata <= {4'b0, cur_item.page_index, cur_item.color, cur_item.y_end,
                    cur_item.y_start, cur_item.x_end, cur_item.x_start};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. Before each result transaction it may hold tready low, except in
  // one stretch of 40 results out of every three, where tready stays high.
  // ---------------------------------------------------------------------------
  int out_stall = 0;

  always @(negedge clk) begin
    if (!rst) begin
      if (out_fire)
        out_stall = ((results_taken / 40) % 3 == 1) ? 0 : $urandom_range(0, 7);
      if (out_stall > 0) begin
        out_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Both streams are sampled at the rising edge: an accepted item is
  // applied to the shadow store, an accepted result is checked against the
  // oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    item_t it;
    result_t want;
    in_fire  <= s_tvalid && s_tready && !rst;
    out_fire <= m_tvalid && m_tready && !rst;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        it.operation  = s_tuser;
        it.x_start    = s_tdata[7:0];
        it.x_end      = s_tdata[15:8];
        it.y_start    = s_tdata[23:16];
        it.y_end      = s_tdata[31:24];
        it.color      = s_tdata[32];
        it.page_index = s_tdata[35:33];
        apply_draw_item(it);
        items_taken++;
      end
      if (m_tvalid && m_tready) begin
        results_taken++;
        if (panel_q.size() == 0) begin
          mismatches++;
          $error("result transaction with nothing expected: tdata %h", m_tdata);
        end else begin
          want = panel_q.pop_front();
          if (m_tuser !== want.is_data) begin
            mismatches++;
            $error("is_data: expected %0d, actual %0d", want.is_data, m_tuser);
          end
          if (m_tdata[3:0] !== want.byte_count) begin
            mismatches++;
            $error("byte_count: expected %0d, actual %0d", want.byte_count, m_tdata[3:0]);
          end
          if (m_tdata[67:4] !== want.payload) begin
            mismatches++;
            $error("payload: expected %h, actual %h", want.payload, m_tdata[67:4]);
          end
          if (m_tdata[68] !== want.pixel_value) begin
            mismatches++;
            $error("pixel_value: expected %0d, actual %0d", want.pixel_value, m_tdata[68]);
          end
          if (m_tlast !== want.last) begin
            mismatches++;
            $error("last: expected %0d, actual %0d", want.last, m_tlast);
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: a run in which nothing moves for too long has hung.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed items, random items, drain and verdict.
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < PANEL_WIDTH * 8; i++) shadow_fb[i] = '0;
    for (int p = 0; p < 8; p++) reset_mark(p);

    // Corners of the panel, then reads of them and of points just off it.
    add_item(OP_SET_PIXEL, 0, 0, 0, 0, 1'b1, 0);
    add_item(OP_SET_PIXEL, 127, 0, 63, 0, 1'b1, 0);
    add_item(OP_GET_PIXEL, 0, 0, 0, 0, 1'b0, 0);
    add_item(OP_GET_PIXEL, 127, 0, 63, 0, 1'b0, 0);
    add_item(OP_GET_PIXEL, 128, 0, 0, 0, 1'b0, 0);
    add_item(OP_GET_PIXEL, 0, 0, 64, 0, 1'b0, 0);
    // A pixel off the panel is ignored; so are lines starting off the panel.
    add_item(OP_SET_PIXEL, 255, 255, 255, 255, 1'b1, 7);
    add_item(OP_HLINE, 128, 200, 5, 0, 1'b1, 0);
    add_item(OP_VLINE, 3, 0, 64, 255, 1'b1, 0);
    // A full-width line whose end is clamped, and a reversed one.
    add_item(OP_HLINE, 0, 255, 13, 0, 1'b1, 0);
    add_item(OP_HLINE, 50, 10, 20, 0, 1'b1, 0);
    // A vertical line through every page, clamped, and a reversed one.
    add_item(OP_VLINE, 70, 0, 0, 255, 1'b1, 0);
    add_item(OP_VLINE, 71, 0, 40, 30, 1'b1, 0);
    add_item(OP_SET_PIXEL, 70, 0, 33, 0, 1'b0, 0);
    add_item(OP_GET_PIXEL, 70, 0, 33, 0, 1'b0, 0);
    add_item(OP_GET_PIXEL, 70, 0, 34, 0, 1'b0, 0);
    // Flush a dirty page, then the same page again now that it is clean.
    add_item(OP_FLUSH_PAGE, 0, 0, 0, 0, 1'b0, 1);
    add_item(OP_FLUSH_PAGE, 0, 0, 0, 0, 1'b0, 1);
    add_item(OP_FLUSH_PAGE, 0, 0, 0, 0, 1'b0, 7);
    // Clears with both fills; a clear leaves its page clean.
    add_item(OP_CLEAR_PAGE, 0, 0, 0, 0, 1'b1, 2);
    add_item(OP_CLEAR_PAGE, 0, 0, 0, 0, 1'b0, 0);
    add_item(OP_FLUSH_PAGE, 0, 0, 0, 0, 1'b0, 2);
    add_item(OP_GET_PIXEL, 9, 0, 17, 0, 1'b0, 0);
    add_item(OP_SPARE_LO, 255, 255, 255, 255, 1'b1, 7);
    add_item(OP_SPARE_HI, 0, 0, 0, 0, 1'b0, 0);

    // Mostly well-formed drawing with flushes; about one in eight is followed by noise.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      add_sensible_item();
      if ($urandom_range(0, 7) == 0) add_noise_item();
    end
    for (int p = 0; p < NUM_PAGES; p++)
      add_item(OP_FLUSH_PAGE, 0, 0, 0, 0, 1'b0, p);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (draw_q.size() > 0 || in_busy || s_tvalid) @(posedge clk);
    while (panel_q.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && panel_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mpfb_pkg.sv
rtl/mpfb_store.sv
rtl/mpfb_marks.sv
rtl/mpfb_ctrl.sv
rtl/mpfb_obuf.sv
rtl/mono_page_framebuffer_dirty_flush.sv
sim/tb_top.sv
